FILE: rtl/core/lpht_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpht_pkg: shared types and constants of the linear-probing hash table
// Slot geometry, the slot entry layout, memory port requests and status codes.
// ----------------------------------------------------------------------------
package lpht_pkg;

    localparam int SLOTS       = 1024;
    localparam int VALUE_BITS  = 32;
    localparam int KEY_BITS    = 64;
    localparam int SLOT_BITS   = $clog2(SLOTS);
    localparam int COUNT_BITS  = $clog2(SLOTS + 1);

    localparam logic [SLOT_BITS-1:0] SLOT_LAST = SLOT_BITS'(SLOTS - 1);

    // Result status codes.
    typedef enum logic [2:0] {
        STAT_INSERTED  = 3'd0,
        STAT_UPDATED   = 3'd1,
        STAT_FULL      = 3'd2,
        STAT_FOUND     = 3'd3,
        STAT_NOT_FOUND = 3'd4,
        STAT_REJECTED  = 3'd5
    } status_t;

    // Request kinds carried in the input tuser bit.
    localparam logic ACT_INSERT = 1'b0;
    localparam logic ACT_LOOKUP = 1'b1;

    typedef struct packed {
        logic                  valid;
        logic [KEY_BITS-1:0]   key;
        logic [VALUE_BITS-1:0] value;
    } slot_entry_t;

    typedef struct packed {
        logic                 en;
        logic [SLOT_BITS-1:0] addr;
        slot_entry_t          entry;
    } slot_wr_t;

    typedef struct packed {
        logic                 en;
        logic [SLOT_BITS-1:0] addr;
    } slot_rd_t;

endpackage

FILE: rtl/core/lpht_slot_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpht_slot_ram: slot store of the hash table
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module lpht_slot_ram
    import lpht_pkg::*;
(
    input  logic        clk,
    input  slot_wr_t    wr,
    input  slot_rd_t    rd,
    output slot_entry_t rd_entry
);

    slot_entry_t mem [SLOTS];
    slot_entry_t rd_entry_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.entry;
        end
        if (rd.en)
        begin
            rd_entry_reg <= mem[rd.addr];
        end
    end

    assign rd_entry = rd_entry_reg;

endmodule

FILE: rtl/core/linear_probe_hash_table_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// linear_probe_hash_table_top: open-addressing hash table, linear probing
// Insert/update and lookup by 64-bit key over a power-of-two slot store.
//
//   Channel   Direction  Contents
//   s_axis    in         tdata: key, value; tuser: action
//   m_axis    out        tdata: found_value, entry_count; tuser: status
//   apb       in/out     register 0 at 0x0: reserved_key (64 bits)
//
// After reset a clearing pass writes every slot empty, one slot per cycle;
// no transaction is accepted until it ends.
// Each probed slot is read in ST_PROBE and compared in ST_CHECK, bounded by the one
// read port of the slot store; a reserved key is rejected in ST_PROBE without a read.
// One request is in flight at a time; the result register lets the next
// request start while the previous result still waits on m_axis_tready.
// ----------------------------------------------------------------------------
module linear_probe_hash_table_top
    import lpht_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    // slave stream
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [95:0]  s_axis_tdata,   // [63:0] key, [95:64] value
    input  logic         s_axis_tuser,   // [0] action
    // master stream
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [47:0]  m_axis_tdata,   // [31:0] found_value, [42:32] entry_count
    output logic [2:0]   m_axis_tuser,   // [2:0] status
    // configuration
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [3:0]   paddr,
    input  logic [63:0]  pwdata,
    output logic [63:0]  prdata,
    output logic         pready
);

    typedef enum logic [4:0] {
        ST_CLEAR = 5'b00001,
        ST_IDLE  = 5'b00010,
        ST_PROBE = 5'b00100,
        ST_CHECK = 5'b01000,
        ST_DONE  = 5'b10000
    } state_t;

    state_t                 state_reg, state_next;
    logic [SLOT_BITS-1:0]   clr_reg, clr_next;
    logic [SLOT_BITS-1:0]   idx_reg, idx_next;
    logic [SLOT_BITS-1:0]   probe_reg, probe_next;
    logic [COUNT_BITS-1:0]  count_reg, count_next;
    logic                   out_valid_reg, out_valid_next;
    logic [KEY_BITS-1:0]    reserved_key_reg;

    logic                   action_reg;
    logic [KEY_BITS-1:0]    key_reg;
    logic [VALUE_BITS-1:0]  value_reg;
    status_t                res_status_reg, res_status_next;
    logic [31:0]            res_value_reg, res_value_next;
    status_t                out_status_reg;
    logic [31:0]            out_value_reg;
    logic [COUNT_BITS-1:0]  out_count_reg;

    slot_wr_t               wr;
    slot_rd_t               rd;
    slot_entry_t            rd_entry;

    logic                   in_accept;
    logic                   out_free;
    logic                   cfg_write;
    logic                   hit_empty;
    logic                   hit_match;

    lpht_slot_ram u_slot_ram (
        .clk      (clk),
        .wr       (wr),
        .rd       (rd),
        .rd_entry (rd_entry)
    );

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && (paddr[3] == 1'b0);
    assign prdata    = (paddr[3] == 1'b0) ? reserved_key_reg : 64'd0;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign out_free      = !out_valid_reg || m_axis_tready;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_status_reg;
    assign m_axis_tdata  = {{(48 - 32 - COUNT_BITS){1'b0}}, out_count_reg, out_value_reg};

    assign hit_empty = !rd_entry.valid;
    assign hit_match = (rd_entry.key == key_reg);

    always_comb
    begin
        state_next      = state_reg;
        clr_next        = clr_reg;
        idx_next        = idx_reg;
        probe_next      = probe_reg;
        count_next      = count_reg;
        out_valid_next  = out_valid_reg;
        res_status_next = res_status_reg;
        res_value_next  = res_value_reg;
        wr              = '0;
        rd              = '0;

        if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_CLEAR:
            begin
                wr.en    = 1'b1;
                wr.addr  = clr_reg;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == SLOT_LAST)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    idx_next   = s_axis_tdata[SLOT_BITS-1:0];
                    probe_next = '0;
                    state_next = ST_PROBE;
                end
            end
            ST_PROBE:
            begin
                if (key_reg == reserved_key_reg)
                begin
                    res_status_next = STAT_REJECTED;
                    res_value_next  = '0;
                    state_next      = ST_DONE;
                end
                else
                begin
                    rd.en      = 1'b1;
                    rd.addr    = idx_reg;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                res_value_next = '0;
                if (hit_empty)
                begin
                    state_next = ST_DONE;
                    if (action_reg == ACT_LOOKUP)
                    begin
                        res_status_next = STAT_NOT_FOUND;
                    end
                    else
                    begin
                        wr.en           = 1'b1;
                        wr.addr         = idx_reg;
                        wr.entry        = '{valid: 1'b1, key: key_reg, value: value_reg};
                        count_next      = count_reg + 1'b1;
                        res_status_next = STAT_INSERTED;
                    end
                end
                else if (hit_match)
                begin
                    state_next = ST_DONE;
                    if (action_reg == ACT_LOOKUP)
                    begin
                        res_status_next = STAT_FOUND;
                        res_value_next  = 32'(rd_entry.value);
                    end
                    else
                    begin
                        wr.en           = 1'b1;
                        wr.addr         = idx_reg;
                        wr.entry        = '{valid: 1'b1, key: key_reg, value: value_reg};
                        res_status_next = STAT_UPDATED;
                    end
                end
                else if (probe_reg == SLOT_LAST)
                begin
                    // Every slot was visited without an empty slot or the key.
                    state_next      = ST_DONE;
                    res_status_next = (action_reg == ACT_LOOKUP) ? STAT_NOT_FOUND
                                                                 : STAT_FULL;
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    probe_next = probe_reg + 1'b1;
                    state_next = ST_PROBE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_CLEAR;
            clr_reg          <= '0;
            idx_reg          <= '0;
            probe_reg        <= '0;
            count_reg        <= '0;
            out_valid_reg    <= 1'b0;
            reserved_key_reg <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            idx_reg       <= idx_next;
            probe_reg     <= probe_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
            if (cfg_write)
            begin
                reserved_key_reg <= pwdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        res_status_reg <= res_status_next;
        res_value_reg  <= res_value_next;
        if (in_accept)
        begin
            action_reg <= s_axis_tuser;
            key_reg    <= s_axis_tdata[63:0];
            value_reg  <= VALUE_BITS'(s_axis_tdata[95:64]);
        end
        if ((state_reg == ST_DONE) && out_free)
        begin
            out_status_reg <= res_status_reg;
            out_value_reg  <= res_value_reg;
            out_count_reg  <= count_reg;
        end
    end

endmodule
